### sv/assert_macros.svh
// Assertion macros for the transfer unit RTL.
// Included by modules that check their own logic; compiles to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### sv/i2c_mrt_pkg.sv
// Types and constants for the I2C master register transfer unit.
// No dependencies; used by all modules and the bench.
package i2c_mrt_pkg;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_EVENT = 2'd3
    } cmd_t;

    // Bus actions handed to the byte engine
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_START     = 3'd1,
        ACT_SEND      = 3'd2,
        ACT_RECV_ACK  = 3'd3,
        ACT_RECV_NACK = 3'd4,
        ACT_STOP      = 3'd5
    } action_t;

    // Transfer phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_W_START = 9'b000000010,
        PH_W_SLA   = 9'b000000100,
        PH_W_ADDR  = 9'b000001000,
        PH_W_DATA  = 9'b000010000,
        PH_R_START = 9'b000100000,
        PH_R_SLA   = 9'b001000000,
        PH_R_MORE  = 9'b010000000,
        PH_R_LAST  = 9'b100000000
    } phase_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ID_HIGH     = 2'd0;
    localparam logic [1:0] CFG_DEVICE_SUB_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_ATTEMPT_LIMIT      = 2'd2;

    localparam logic [3:0] RST_DEVICE_ID_HIGH     = 4'd10;
    localparam logic [2:0] RST_DEVICE_SUB_ADDRESS = 3'd1;
    localparam logic [3:0] RST_ATTEMPT_LIMIT      = 4'd10;

    // Bus engine status codes after masking
    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_REP_START   = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK = 8'h20;
    localparam logic [7:0] ST_MT_DATA_ACK = 8'h28;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK = 8'h48;
    localparam logic [7:0] ST_MR_DATA_ACK = 8'h50;
    localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

    localparam logic [4:0] MAX_LEN = 5'd16;

    typedef struct packed {
        logic [3:0] device_id_high;
        logic [2:0] device_sub_address;
        logic [3:0] attempt_limit;
    } cfg_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] register_address;
        logic [4:0] byte_count;
        logic [7:0] data_byte;
        logic [7:0] bus_status;
    } in_item_t;

    typedef struct packed {
        action_t    bus_action;
        logic [7:0] send_byte;
        logic       received_valid;
        logic [7:0] received_byte;
        logic       finished;
        logic       success;
    } res_t;

    // Sequencer to write buffer control
    typedef struct packed {
        logic       load_en;
        logic [7:0] load_data;
        logic       rewind;
        logic       advance;
    } buf_ctrl_t;

endpackage

### sv/i2c_mrt_req_if.sv
// Input channel of the transfer unit: commands and bus status events.
// Standalone; no package needed.
interface i2c_mrt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] register_address;
    logic [4:0] byte_count;
    logic [7:0] data_byte;
    logic [7:0] bus_status;

    modport source (
        output valid, cmd, register_address, byte_count, data_byte, bus_status,
        input  ready
    );
    modport sink (
        input  valid, cmd, register_address, byte_count, data_byte, bus_status,
        output ready
    );
endinterface

### sv/i2c_mrt_rsp_if.sv
// Output channel of the transfer unit: bus actions and transfer results.
// Standalone; no package needed.
interface i2c_mrt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] bus_action;
    logic [7:0] send_byte;
    logic       received_valid;
    logic [7:0] received_byte;
    logic       finished;
    logic       success;

    modport source (
        output valid, bus_action, send_byte, received_valid, received_byte, finished,
               success,
        input  ready
    );
    modport sink (
        input  valid, bus_action, send_byte, received_valid, received_byte, finished,
               success,
        output ready
    );
endinterface

### sv/i2c_mrt_wbuf.sv
// Write data buffer: load pointer, fetch pointer and a memory with registered read.
// Depends on i2c_mrt_pkg.
module i2c_mrt_wbuf #(
    parameter int DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2c_mrt_pkg::buf_ctrl_t ctrl,
    output logic [7:0]            rd_data
);
    import i2c_mrt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] load_ptr_reg;
    logic [AW-1:0] load_ptr_next;
    logic [AW-1:0] fetch_ptr_reg;
    logic [AW-1:0] fetch_ptr_next;
    logic [7:0]    rd_data_reg;

    // Pointer stepping with wrap at the buffer depth
    always_comb
    begin
        load_ptr_next  = load_ptr_reg;
        fetch_ptr_next = fetch_ptr_reg;
        if (ctrl.rewind)
        begin
            load_ptr_next  = '0;
            fetch_ptr_next = '0;
        end
        else
        begin
            if (ctrl.load_en)
                load_ptr_next = (load_ptr_reg == LAST_IDX) ? '0 : load_ptr_reg + 1'b1;
            if (ctrl.advance)
                fetch_ptr_next = (fetch_ptr_reg == LAST_IDX) ? '0 : fetch_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_ptr_reg  <= '0;
            fetch_ptr_reg <= '0;
        end
        else
        begin
            load_ptr_reg  <= load_ptr_next;
            fetch_ptr_reg <= fetch_ptr_next;
        end
    end

    // Memory: one write port, registered read of the next byte to send
    always_ff @(posedge clk)
    begin
        if (ctrl.load_en)
            mem[load_ptr_reg] <= ctrl.load_data;
        rd_data_reg <= mem[fetch_ptr_next];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/i2c_mrt_seq.sv
// Transfer sequencer: input register, phase state machine and result register.
// Depends on i2c_mrt_pkg, the channel interfaces and assert_macros.svh.
`include "assert_macros.svh"

module i2c_mrt_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    i2c_mrt_req_if.sink            req,
    i2c_mrt_rsp_if.source          rsp,
    input  i2c_mrt_pkg::cfg_t      cfg,
    input  logic [7:0]             buf_data,
    output i2c_mrt_pkg::buf_ctrl_t buf_ctrl
);
    import i2c_mrt_pkg::*;

    // Input stage
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     out_free;
    logic     process;

    // Transfer state
    phase_t     phase_reg, phase_next;
    logic [3:0] att_reg, att_next;
    logic [4:0] pos_reg, pos_next;
    logic [4:0] len_reg, len_next;
    logic [3:0] addr_reg, addr_next;
    logic       rd_reg, rd_next;

    // Result stage
    logic  o_valid_reg;
    res_t  o_res_reg;
    res_t  res_next;
    logic  emit;
    logic  res_load;

    // Decode helpers
    logic [7:0] st;
    logic       st_is_start;
    logic       do_retry;
    logic       do_fail;
    logic [3:0] att_base;
    logic [4:0] pos_inc;
    logic [4:0] cnt_clamped;
    logic [7:0] slave_w;
    logic [7:0] slave_r;

    assign out_free  = !o_valid_reg || rsp.ready;
    assign process   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign res_load  = process && emit;

    assign st          = s1_item_reg.bus_status & STATUS_MASK;
    assign st_is_start = (st == ST_START) || (st == ST_REP_START);
    assign pos_inc     = pos_reg + 5'd1;
    assign slave_w     = {cfg.device_id_high, cfg.device_sub_address, 1'b0};
    assign slave_r     = {cfg.device_id_high, cfg.device_sub_address, 1'b1};
    assign cnt_clamped = (s1_item_reg.byte_count == 5'd0)   ? 5'd1 :
                         (s1_item_reg.byte_count > MAX_LEN) ? MAX_LEN :
                         s1_item_reg.byte_count;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req.ready)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_item_reg.cmd              <= cmd_t'(req.cmd);
            s1_item_reg.register_address <= req.register_address;
            s1_item_reg.byte_count       <= req.byte_count;
            s1_item_reg.data_byte        <= req.data_byte;
            s1_item_reg.bus_status       <= req.bus_status;
        end
    end

    // Next state and result for the item in the input register
    always_comb
    begin
        phase_next = phase_reg;
        att_next   = att_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        addr_next  = addr_reg;
        rd_next    = rd_reg;
        res_next   = '0;
        emit       = 1'b0;
        do_retry   = 1'b0;
        do_fail    = 1'b0;
        att_base   = att_reg;
        buf_ctrl   = '0;

        if (process)
        begin
            unique case (s1_item_reg.cmd) inside
                CMD_LOAD:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        buf_ctrl.load_en   = 1'b1;
                        buf_ctrl.load_data = s1_item_reg.data_byte;
                    end
                end
                CMD_WRITE, CMD_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        len_next  = cnt_clamped;
                        addr_next = s1_item_reg.register_address;
                        rd_next   = (s1_item_reg.cmd == CMD_READ);
                        pos_next  = '0;
                        att_base  = '0;
                        emit      = 1'b1;
                        do_retry  = 1'b1;
                    end
                end
                CMD_EVENT:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        emit = 1'b1;
                        unique case (phase_reg)
                            PH_W_START:
                            begin
                                if (st == ST_ARB_LOST)
                                    do_retry = 1'b1;
                                else if (!st_is_start)
                                    do_fail = 1'b1;
                                else
                                begin
                                    phase_next          = PH_W_SLA;
                                    res_next.bus_action = ACT_SEND;
                                    res_next.send_byte  = slave_w;
                                end
                            end
                            PH_W_SLA:
                            begin
                                if (st == ST_MT_SLA_NACK || st == ST_ARB_LOST)
                                    do_retry = 1'b1;
                                else if (st != ST_MT_SLA_ACK)
                                    do_fail = 1'b1;
                                else
                                begin
                                    phase_next          = PH_W_ADDR;
                                    res_next.bus_action = ACT_SEND;
                                    res_next.send_byte  = {4'd0, addr_reg};
                                end
                            end
                            PH_W_ADDR:
                            begin
                                if (st != ST_MT_DATA_ACK)
                                    do_fail = 1'b1;
                                else
                                begin
                                    pos_next = '0;
                                    if (rd_reg)
                                    begin
                                        phase_next          = PH_R_START;
                                        res_next.bus_action = ACT_START;
                                    end
                                    else
                                    begin
                                        phase_next          = PH_W_DATA;
                                        res_next.bus_action = ACT_SEND;
                                        res_next.send_byte  = buf_data;
                                        buf_ctrl.advance    = 1'b1;
                                    end
                                end
                            end
                            PH_W_DATA:
                            begin
                                if (st != ST_MT_DATA_ACK)
                                    do_fail = 1'b1;
                                else
                                begin
                                    pos_next = pos_inc;
                                    if (pos_inc < len_reg)
                                    begin
                                        res_next.bus_action = ACT_SEND;
                                        res_next.send_byte  = buf_data;
                                        buf_ctrl.advance    = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next          = PH_IDLE;
                                        res_next.bus_action = ACT_STOP;
                                        res_next.finished   = 1'b1;
                                        res_next.success    = 1'b1;
                                    end
                                end
                            end
                            PH_R_START:
                            begin
                                if (st == ST_ARB_LOST)
                                    do_retry = 1'b1;
                                else if (!st_is_start)
                                    do_fail = 1'b1;
                                else
                                begin
                                    phase_next          = PH_R_SLA;
                                    res_next.bus_action = ACT_SEND;
                                    res_next.send_byte  = slave_r;
                                end
                            end
                            PH_R_SLA:
                            begin
                                if (st == ST_MR_SLA_NACK || st == ST_ARB_LOST)
                                    do_retry = 1'b1;
                                else if (st != ST_MR_SLA_ACK)
                                    do_fail = 1'b1;
                                else
                                begin
                                    pos_next = '0;
                                    if (len_reg > 5'd1)
                                    begin
                                        phase_next          = PH_R_MORE;
                                        res_next.bus_action = ACT_RECV_ACK;
                                    end
                                    else
                                    begin
                                        phase_next          = PH_R_LAST;
                                        res_next.bus_action = ACT_RECV_NACK;
                                    end
                                end
                            end
                            PH_R_MORE:
                            begin
                                if (st != ST_MR_DATA_ACK)
                                    do_fail = 1'b1;
                                else
                                begin
                                    pos_next                = pos_inc;
                                    res_next.received_valid = 1'b1;
                                    res_next.received_byte  = s1_item_reg.data_byte;
                                    if (({1'b0, pos_inc} + 6'd1) < {1'b0, len_reg})
                                        res_next.bus_action = ACT_RECV_ACK;
                                    else
                                    begin
                                        phase_next          = PH_R_LAST;
                                        res_next.bus_action = ACT_RECV_NACK;
                                    end
                                end
                            end
                            PH_R_LAST:
                            begin
                                if (st != ST_MR_DATA_NACK)
                                    do_fail = 1'b1;
                                else
                                begin
                                    phase_next              = PH_IDLE;
                                    res_next.bus_action     = ACT_STOP;
                                    res_next.received_valid = 1'b1;
                                    res_next.received_byte  = s1_item_reg.data_byte;
                                    res_next.finished       = 1'b1;
                                    res_next.success        = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next        = PH_IDLE;
                                res_next.finished = 1'b1;
                            end
                        endcase
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase

            // Restart the transfer, or give up once the attempts are used;
            // the buffer pointers go back to the start either way
            if (do_retry)
            begin
                res_next        = '0;
                buf_ctrl.rewind = 1'b1;
                if (att_base >= cfg.attempt_limit)
                begin
                    phase_next          = PH_IDLE;
                    res_next.bus_action = ACT_NONE;
                    res_next.finished   = 1'b1;
                end
                else
                begin
                    att_next            = att_base + 4'd1;
                    phase_next          = PH_W_START;
                    res_next.bus_action = ACT_START;
                end
            end

            // Unexpected status: stop and report failure
            if (do_fail)
            begin
                phase_next          = PH_IDLE;
                res_next            = '0;
                res_next.bus_action = ACT_STOP;
                res_next.finished   = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            att_reg   <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            addr_reg  <= '0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            att_reg   <= att_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            addr_reg  <= addr_next;
            rd_reg    <= rd_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (res_load)
            o_valid_reg <= 1'b1;
        else if (rsp.ready)
            o_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            o_res_reg <= res_next;
    end

    assign rsp.valid          = o_valid_reg;
    assign rsp.bus_action     = o_res_reg.bus_action;
    assign rsp.send_byte      = o_res_reg.send_byte;
    assign rsp.received_valid = o_res_reg.received_valid;
    assign rsp.received_byte  = o_res_reg.received_byte;
    assign rsp.finished       = o_res_reg.finished;
    assign rsp.success        = o_res_reg.success;

    // A finishing result always returns the sequencer to idle
    `ASSERT_PROP(a_finish_idle, clk, rst_n, (res_load && res_next.finished) |=> (phase_reg == PH_IDLE), "finished result left sequencer busy")
    // Received bytes only ride on receive or stop actions
    `ASSERT_PROP(a_rx_action, clk, rst_n, (res_load && res_next.received_valid) |-> (res_next.bus_action == ACT_RECV_ACK || res_next.bus_action == ACT_RECV_NACK || res_next.bus_action == ACT_STOP), "received byte with wrong action")
    // Buffer load and pointer rewind never coincide
    `ASSERT_NEVER(a_load_rewind, clk, rst_n, buf_ctrl.load_en && buf_ctrl.rewind, "buffer load during rewind")

endmodule

### sv/i2c_master_register_transfer_unit.sv
// Top level of the I2C master register transfer unit: configuration registers,
// sequencer and write buffer. Depends on i2c_mrt_pkg, the channel interfaces and submodules.
//
//   Channel  Dir  Handshake      Carries
//   req      in   valid/ready    cmd, register_address, byte_count, data_byte, bus_status
//   rsp      out  valid/ready    bus_action, send_byte, received_valid, received_byte,
//                                finished, success
//   cfg      in   cfg_we         cfg_index, cfg_wdata (write only)
//
// One item per cycle while rsp is not stalled; an accepted item waits in the input register
// until the result register is free, and its result then loads there. A stalled rsp holds
// the result register and backs up req through the input register. Reset clears control
// state and restores configuration defaults; the write buffer needs no clearing.
module i2c_master_register_transfer_unit #(
    parameter int BUFFER_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    i2c_mrt_req_if.sink    req,
    i2c_mrt_rsp_if.source  rsp,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [3:0]     cfg_wdata
);
    import i2c_mrt_pkg::*;

    cfg_t      cfg_reg;
    buf_ctrl_t buf_ctrl;
    logic [7:0] buf_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id_high     <= RST_DEVICE_ID_HIGH;
            cfg_reg.device_sub_address <= RST_DEVICE_SUB_ADDRESS;
            cfg_reg.attempt_limit      <= RST_ATTEMPT_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEVICE_ID_HIGH:     cfg_reg.device_id_high     <= cfg_wdata;
                CFG_DEVICE_SUB_ADDRESS: cfg_reg.device_sub_address <= cfg_wdata[2:0];
                CFG_ATTEMPT_LIMIT:      cfg_reg.attempt_limit      <= cfg_wdata;
                default:                cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    i2c_mrt_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg      (cfg_reg),
        .buf_data (buf_data),
        .buf_ctrl (buf_ctrl)
    );

    i2c_mrt_wbuf #(
        .DEPTH (BUFFER_DEPTH)
    ) u_wbuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (buf_ctrl),
        .rd_data (buf_data)
    );

endmodule

### bench/tb_top.sv
// Self-checking bench for the I2C master register transfer unit: random and directed
// commands and bus status items, results checked against a cycle-free transfer predictor.
// Depends on i2c_mrt_pkg, i2c_mrt_req_if, i2c_mrt_rsp_if and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;
    import i2c_mrt_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int SETTLE_CYCLES   = 8;
    localparam int LIMIT_NS        = 5_000_000;

    // Transfer state as the predictor sees it, configuration included
    typedef struct packed {
        cfg_t             cfg;
        phase_t           ph;
        logic [3:0]       tries_used;
        logic [4:0]       pos;
        logic [4:0]       len;
        logic [3:0]       reg_addr;
        logic             rd;
        logic [3:0]       load_ptr;
        logic [15:0][7:0] wbuf;
    } xfer_state_t;

    typedef struct packed {
        in_item_t item;
        logic     hold;
    } pending_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_wdata;

    i2c_mrt_req_if req_ch ();
    i2c_mrt_rsp_if rsp_ch ();

    i2c_master_register_transfer_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // model_st follows accepted items, plan_st follows generated items
    xfer_state_t model_st;
    xfer_state_t plan_st;
    pending_t    pending_items[$];
    res_t        expected_results[$];
    in_item_t    cur_item;
    logic [15:0] loaded_mask;
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_pct;
    bit          hold_once;

    always #5 clk = ~clk;

    task automatic report_mismatch(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic xfer_state_t reset_state();
        xfer_state_t s;
        s = '0;
        s.cfg.device_id_high     = RST_DEVICE_ID_HIGH;
        s.cfg.device_sub_address = RST_DEVICE_SUB_ADDRESS;
        s.cfg.attempt_limit      = RST_ATTEMPT_LIMIT;
        s.ph = PH_IDLE;
        return s;
    endfunction

    function automatic res_t mk_res(action_t a, logic [7:0] sb, logic rv, logic [7:0] rb,
                                    logic fin, logic ok);
        res_t r;
        r.bus_action     = a;
        r.send_byte      = sb;
        r.received_valid = rv;
        r.received_byte  = rb;
        r.finished       = fin;
        r.success        = ok;
        return r;
    endfunction

    // Restart from the top, or give up quietly once the attempts are used
    function automatic res_t retry_xfer(inout xfer_state_t s);
        if (s.tries_used >= s.cfg.attempt_limit)
        begin
            s.ph = PH_IDLE;
            return mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
        end
        s.tries_used = s.tries_used + 4'd1;
        s.ph = PH_W_START;
        return mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
    endfunction

    function automatic res_t abort_stop(inout xfer_state_t s);
        s.ph = PH_IDLE;
        return mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
    endfunction

    // One item through the transfer sequencer; returns 1 when a result comes out
    function automatic bit step_xfer(inout xfer_state_t s, input in_item_t it, output res_t r);
        logic [7:0] st;
        logic [4:0] cnt;
        logic [7:0] sla;
        logic       is_start;
        st       = it.bus_status & STATUS_MASK;
        sla      = {s.cfg.device_id_high, s.cfg.device_sub_address, 1'b0};
        is_start = (st == ST_START) || (st == ST_REP_START);
        r        = '0;
        if (it.cmd == CMD_LOAD)
        begin
            if (s.ph == PH_IDLE)
            begin
                s.wbuf[s.load_ptr] = it.data_byte;
                s.load_ptr = s.load_ptr + 4'd1;
            end
            return 1'b0;
        end
        if (it.cmd != CMD_EVENT)
        begin
            if (s.ph != PH_IDLE)
                return 1'b0;
            cnt = it.byte_count;
            if (cnt == 5'd0)
                cnt = 5'd1;
            if (cnt > MAX_LEN)
                cnt = MAX_LEN;
            s.len        = cnt;
            s.reg_addr   = it.register_address;
            s.rd         = (it.cmd == CMD_READ);
            s.pos        = '0;
            s.tries_used = '0;
            s.load_ptr   = '0;
            r = retry_xfer(s);
            return 1'b1;
        end
        if (s.ph == PH_IDLE)
            return 1'b0;
        case (s.ph)
            PH_W_START:
            begin
                if (st == ST_ARB_LOST)
                    r = retry_xfer(s);
                else if (!is_start)
                    r = abort_stop(s);
                else
                begin
                    s.ph = PH_W_SLA;
                    r = mk_res(ACT_SEND, sla, 1'b0, 8'h00, 1'b0, 1'b0);
                end
            end
            PH_W_SLA:
            begin
                if (st == ST_MT_SLA_NACK || st == ST_ARB_LOST)
                    r = retry_xfer(s);
                else if (st != ST_MT_SLA_ACK)
                    r = abort_stop(s);
                else
                begin
                    s.ph = PH_W_ADDR;
                    r = mk_res(ACT_SEND, {4'h0, s.reg_addr}, 1'b0, 8'h00, 1'b0, 1'b0);
                end
            end
            PH_W_ADDR:
            begin
                if (st != ST_MT_DATA_ACK)
                    r = abort_stop(s);
                else
                begin
                    s.pos = '0;
                    if (s.rd)
                    begin
                        s.ph = PH_R_START;
                        r = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                    end
                    else
                    begin
                        s.ph = PH_W_DATA;
                        r = mk_res(ACT_SEND, s.wbuf[0], 1'b0, 8'h00, 1'b0, 1'b0);
                    end
                end
            end
            PH_W_DATA:
            begin
                if (st != ST_MT_DATA_ACK)
                    r = abort_stop(s);
                else
                begin
                    s.pos = s.pos + 5'd1;
                    if (s.pos < s.len)
                        r = mk_res(ACT_SEND, s.wbuf[s.pos[3:0]], 1'b0, 8'h00, 1'b0, 1'b0);
                    else
                    begin
                        s.ph = PH_IDLE;
                        r = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1);
                    end
                end
            end
            PH_R_START:
            begin
                if (st == ST_ARB_LOST)
                    r = retry_xfer(s);
                else if (!is_start)
                    r = abort_stop(s);
                else
                begin
                    s.ph = PH_R_SLA;
                    r = mk_res(ACT_SEND, sla | 8'h01, 1'b0, 8'h00, 1'b0, 1'b0);
                end
            end
            PH_R_SLA:
            begin
                if (st == ST_MR_SLA_NACK || st == ST_ARB_LOST)
                    r = retry_xfer(s);
                else if (st != ST_MR_SLA_ACK)
                    r = abort_stop(s);
                else
                begin
                    s.pos = '0;
                    if (s.len > 5'd1)
                    begin
                        s.ph = PH_R_MORE;
                        r = mk_res(ACT_RECV_ACK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                    end
                    else
                    begin
                        s.ph = PH_R_LAST;
                        r = mk_res(ACT_RECV_NACK, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
                    end
                end
            end
            PH_R_MORE:
            begin
                if (st != ST_MR_DATA_ACK)
                    r = abort_stop(s);
                else
                begin
                    s.pos = s.pos + 5'd1;
                    if (s.pos + 5'd1 < s.len)
                        r = mk_res(ACT_RECV_ACK, 8'h00, 1'b1, it.data_byte, 1'b0, 1'b0);
                    else
                    begin
                        s.ph = PH_R_LAST;
                        r = mk_res(ACT_RECV_NACK, 8'h00, 1'b1, it.data_byte, 1'b0, 1'b0);
                    end
                end
            end
            PH_R_LAST:
            begin
                if (st != ST_MR_DATA_NACK)
                    r = abort_stop(s);
                else
                begin
                    s.ph = PH_IDLE;
                    r = mk_res(ACT_STOP, 8'h00, 1'b1, it.data_byte, 1'b1, 1'b1);
                end
            end
            default:
            begin
                s.ph = PH_IDLE;
                r = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0);
            end
        endcase
        return 1'b1;
    endfunction

    // Append an item to the send queue; returns 1 unless the block will ignore it
    function automatic int queue_item(cmd_t c, logic [3:0] a, logic [4:0] n, logic [7:0] d,
                                      logic [7:0] st);
        pending_t p;
        res_t     r;
        bit       acted;
        p.item.cmd              = c;
        p.item.register_address = a;
        p.item.byte_count       = n;
        p.item.data_byte        = d;
        p.item.bus_status       = st;
        p.hold    = hold_once || ($urandom_range(99) < hold_pct);
        hold_once = 1'b0;
        acted = (c == CMD_EVENT) ? (plan_st.ph != PH_IDLE) : (plan_st.ph == PH_IDLE);
        if (c == CMD_LOAD && plan_st.ph == PH_IDLE)
            loaded_mask[plan_st.load_ptr] = 1'b1;
        void'(step_xfer(plan_st, p.item, r));
        pending_items.push_back(p);
        return acted ? 1 : 0;
    endfunction

    // Status the bus engine reports when everything goes to plan
    function automatic logic [7:0] good_status(phase_t ph);
        logic [7:0] st;
        case (ph) inside
            PH_W_START, PH_R_START: st = $urandom_range(1) ? ST_START : ST_REP_START;
            PH_W_SLA:               st = ST_MT_SLA_ACK;
            PH_W_ADDR, PH_W_DATA:   st = ST_MT_DATA_ACK;
            PH_R_SLA:               st = ST_MR_SLA_ACK;
            PH_R_MORE:              st = ST_MR_DATA_ACK;
            PH_R_LAST:              st = ST_MR_DATA_NACK;
            default:                st = ST_START;
        endcase
        // low three bits are masked off by the block
        return st | 8'($urandom_range(7));
    endfunction

    // Mostly complete transfers with random content; some carry bus faults
    task automatic gen_transfers(int n);
        int          done;
        int          r;
        int          eff;
        logic [4:0]  cnt;
        logic [7:0]  st;
        logic [15:0] need;
        bit          rd;
        bit          faulty;
        done   = 0;
        faulty = 1'b0;
        while (done < n || plan_st.ph != PH_IDLE)
        begin
            if (plan_st.ph == PH_IDLE)
            begin
                r = $urandom_range(99);
                if (r < 4)
                    done += queue_item(CMD_EVENT, 4'($urandom), 5'($urandom), 8'($urandom),
                                       8'($urandom));
                else if (r < 20)
                    done += queue_item(CMD_LOAD, 4'($urandom), 5'($urandom), 8'($urandom),
                                       8'($urandom));
                else
                begin
                    rd = 1'($urandom_range(1));
                    r  = $urandom_range(99);
                    if (r < 10)
                        cnt = 5'($urandom_range(31));
                    else if (r < 20)
                        cnt = 5'd16;
                    else
                        cnt = 5'($urandom_range(1, 4));
                    eff  = (cnt == 5'd0) ? 1 : (cnt > MAX_LEN) ? 16 : int'(cnt);
                    need = (eff == 16) ? 16'hFFFF : 16'((32'd1 << eff) - 1);
                    // a write must never send a buffer entry that was never loaded
                    if (!rd)
                        while ((loaded_mask & need) != need)
                            done += queue_item(CMD_LOAD, 4'($urandom), 5'($urandom),
                                               8'($urandom), 8'($urandom));
                    faulty = ($urandom_range(99) < 35);
                    done += queue_item(rd ? CMD_READ : CMD_WRITE, 4'($urandom), cnt,
                                       8'($urandom), 8'($urandom));
                end
            end
            else
            begin
                // stray load or start while busy, ignored by the block
                if ($urandom_range(99) < 3)
                    void'(queue_item(cmd_t'($urandom_range(2)), 4'($urandom), 5'($urandom),
                                     8'($urandom), 8'($urandom)));
                r = faulty ? $urandom_range(99) : 99;
                if (r < 6)
                    st = ST_ARB_LOST | 8'($urandom_range(7));
                else if (r < 11)
                    st = ($urandom_range(1) ? ST_MT_SLA_NACK : ST_MR_SLA_NACK)
                         | 8'($urandom_range(7));
                else if (r < 15)
                    st = 8'($urandom);
                else
                    st = good_status(plan_st.ph);
                done += queue_item(CMD_EVENT, 4'($urandom), 5'($urandom), 8'($urandom), st);
            end
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_DEVICE_ID_HIGH:
            begin
                model_st.cfg.device_id_high = val;
                plan_st.cfg.device_id_high  = val;
            end
            CFG_DEVICE_SUB_ADDRESS:
            begin
                model_st.cfg.device_sub_address = val[2:0];
                plan_st.cfg.device_sub_address  = val[2:0];
            end
            CFG_ATTEMPT_LIMIT:
            begin
                model_st.cfg.attempt_limit = val;
                plan_st.cfg.attempt_limit  = val;
            end
            default:
            begin
            end
        endcase
    endtask

    // Wait until everything sent is accepted and every expected result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: predict on acceptance, then present the next item or idle
    always @(posedge clk)
    begin : driver_blk
        res_t     r;
        pending_t nxt;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (step_xfer(model_st, cur_item, r))
                    expected_results.push_back(r);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(pending_items[0].hold && expected_results.size() != 0))
                begin
                    nxt      = pending_items.pop_front();
                    cur_item = nxt.item;
                    req_ch.valid            <= 1'b1;
                    req_ch.cmd              <= nxt.item.cmd;
                    req_ch.register_address <= nxt.item.register_address;
                    req_ch.byte_count       <= nxt.item.byte_count;
                    req_ch.data_byte        <= nxt.item.data_byte;
                    req_ch.bus_status       <= nxt.item.bus_status;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : monitor_blk
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.bus_action     = action_t'(rsp_ch.bus_action);
                got.send_byte      = rsp_ch.send_byte;
                got.received_valid = rsp_ch.received_valid;
                got.received_byte  = rsp_ch.received_byte;
                got.finished       = rsp_ch.finished;
                got.success        = rsp_ch.success;
                if (expected_results.size() == 0)
                    report_mismatch("result item arrived with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (got.bus_action !== want.bus_action)
                        report_mismatch($sformatf("bus_action %0d, expected %0d",
                                                  got.bus_action, want.bus_action));
                    if (got.send_byte !== want.send_byte)
                        report_mismatch($sformatf("send_byte %02h, expected %02h",
                                                  got.send_byte, want.send_byte));
                    if (got.received_valid !== want.received_valid)
                        report_mismatch($sformatf("received_valid %0b, expected %0b",
                                                  got.received_valid, want.received_valid));
                    if (got.received_byte !== want.received_byte)
                        report_mismatch($sformatf("received_byte %02h, expected %02h",
                                                  got.received_byte, want.received_byte));
                    if (got.finished !== want.finished)
                        report_mismatch($sformatf("finished %0b, expected %0b",
                                                  got.finished, want.finished));
                    if (got.success !== want.success)
                        report_mismatch($sformatf("success %0b, expected %0b",
                                                  got.success, want.success));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Run limit
    initial
    begin
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int p;
        clk                     = 1'b0;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_index               = '0;
        cfg_wdata               = '0;
        req_ch.valid            = 1'b0;
        req_ch.cmd              = '0;
        req_ch.register_address = '0;
        req_ch.byte_count       = '0;
        req_ch.data_byte        = '0;
        req_ch.bus_status       = '0;
        rsp_ch.ready            = 1'b0;
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pct       = 0;
        hold_once      = 1'b0;
        loaded_mask    = '0;
        cur_item       = '0;
        model_st       = reset_state();
        plan_st        = reset_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: one-byte write with count zero taken as one
        void'(queue_item(CMD_LOAD, 4'h0, 5'd0, 8'h00, 8'h00));
        void'(queue_item(CMD_LOAD, 4'hF, 5'd31, 8'hFF, 8'hFF));
        void'(queue_item(CMD_WRITE, 4'h0, 5'd0, 8'h00, 8'h00));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_START));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MT_SLA_ACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MT_DATA_ACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MT_DATA_ACK | 8'h07));
        // two-byte read with arbitration loss, stray start and load while busy
        void'(queue_item(CMD_READ, 4'hF, 5'd2, 8'h00, 8'h00));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_REP_START | 8'h07));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_ARB_LOST));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_START));
        void'(queue_item(CMD_WRITE, 4'h5, 5'd31, 8'h00, 8'h00));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MT_SLA_ACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MT_DATA_ACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_REP_START));
        void'(queue_item(CMD_LOAD, 4'h0, 5'd0, 8'h5A, 8'h00));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MR_SLA_ACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'hFF, ST_MR_DATA_ACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MR_DATA_NACK));
        // status while idle, then slave NACK retry and an unexpected status
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_START));
        void'(queue_item(CMD_WRITE, 4'h9, 5'd1, 8'h00, 8'h00));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_START));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_MT_SLA_NACK));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_START));
        void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, 8'h00));

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_drained();
                if (p == 1)
                begin
                    write_reg(CFG_DEVICE_ID_HIGH, 4'd0);
                    write_reg(CFG_DEVICE_SUB_ADDRESS, 4'd0);
                    write_reg(CFG_ATTEMPT_LIMIT, 4'd1);
                end
                else if (p == 2)
                begin
                    write_reg(CFG_DEVICE_ID_HIGH, 4'd15);
                    write_reg(CFG_DEVICE_SUB_ADDRESS, 4'd7);
                    write_reg(CFG_ATTEMPT_LIMIT, 4'd15);
                end
                else
                begin
                    write_reg(CFG_DEVICE_ID_HIGH, 4'($urandom_range(15)));
                    write_reg(CFG_DEVICE_SUB_ADDRESS, 4'($urandom_range(7)));
                    write_reg(CFG_ATTEMPT_LIMIT, $urandom_range(1) ? 4'($urandom_range(1, 3))
                                                                   : 4'($urandom_range(1, 15)));
                end
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            // idle pattern: none, sender gaps, receiver stalls, both
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct  = 20;
                    recv_stall_pct = 20;
                end
            endcase
            hold_pct  = (p == 3 || p == 7) ? 3 : 0;
            hold_once = (p == 3);
            // single attempt: arbitration loss gives up at once, without a stop
            if (p == 1)
            begin
                void'(queue_item(CMD_WRITE, 4'h3, 5'd1, 8'h00, 8'h00));
                void'(queue_item(CMD_EVENT, 4'h0, 5'd0, 8'h00, ST_ARB_LOST));
            end
            gen_transfers(ITEMS_PER_PHASE);
        end
        wait_drained();

        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/i2c_mrt_pkg.sv
sv/i2c_mrt_req_if.sv
sv/i2c_mrt_rsp_if.sv
sv/i2c_mrt_wbuf.sv
sv/i2c_mrt_seq.sv
sv/i2c_master_register_transfer_unit.sv
bench/tb_top.sv
